[hdl/swsb_pkg.sv]
// ----------------------------------------------------------------------------
// swsb_pkg
// shared types and constants for the sliding window slot buffer
// ----------------------------------------------------------------------------
package swsb_pkg;

  localparam int unsigned MaxSlots = 256;
  localparam int unsigned SlotAw   = $clog2(MaxSlots);
  localparam int unsigned SizeW    = SlotAw + 1;
  localparam int unsigned OffW     = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned SumW     = OffW + 1;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [OffW-1:0]   offset;
    logic              write_present;
    logic [ValueW-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic              read_present;
    logic [ValueW-1:0] read_value;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_present;
    logic              rd_en;
    logic [SlotAw-1:0] addr;
  } store_cmd_t;

endpackage

[hdl/swsb_mod_unit.sv]
// ----------------------------------------------------------------------------
// swsb_mod_unit
// iterative remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module swsb_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swsb_pkg::SumW-1:0]  dividend_i,
  input  logic [swsb_pkg::SizeW-1:0] divisor_i,
  output logic                       done_o,
  output logic [swsb_pkg::SlotAw-1:0] rem_o
);
  import swsb_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [SumW-1:0]   dvd_q;
  logic [SizeW-1:0]  rem_q;
  logic [SizeW:0]    trial;
  logic [SizeW:0]    diff;
  logic [SizeW-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[SumW-1]};
    diff  = trial - {1'b0, divisor_i};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = diff[SizeW-1:0];
    end else begin
      rem_d = trial[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SumW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[SlotAw-1:0];

endmodule

[hdl/swsb_slot_store.sv]
// ----------------------------------------------------------------------------
// swsb_slot_store
// slot value memory with per-slot present flags
// ----------------------------------------------------------------------------
module swsb_slot_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swsb_pkg::store_cmd_t        cmd_i,
  input  logic [swsb_pkg::ValueW-1:0] wdata_i,
  output logic                        rd_present_o,
  output logic [swsb_pkg::ValueW-1:0] rd_value_o
);
  import swsb_pkg::*;

  logic [ValueW-1:0]   slot_mem [MaxSlots];
  logic [MaxSlots-1:0] present_q;
  logic                rd_present_q;
  logic [ValueW-1:0]   rd_value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_present) begin
      slot_mem[cmd_i.addr] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rd_value_q <= slot_mem[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      rd_present_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        present_q[cmd_i.addr] <= cmd_i.wr_present;
      end
      if (cmd_i.rd_en) begin
        rd_present_q <= present_q[cmd_i.addr];
      end
    end
  end

  assign rd_present_o = rd_present_q;
  assign rd_value_o   = rd_present_q ? rd_value_q : '0;

endmodule

[hdl/sliding_window_slot_buffer_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_slot_buffer_unit
// window of slots addressed relative to a rotating base index
// ----------------------------------------------------------------------------
// sequence: a read or accepted write runs the remainder unit, while a rejected write or
//   unused request goes straight to the result; an advance by n up to window_size finds
//   the base slot, clears n slots and finds the new base, beyond it clears the window
// throughput: one item at a time, next item taken once the result is registered
// reset: all slots empty, base index zero, window size 256, no clearing pass
module sliding_window_slot_buffer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swsb_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  swsb_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output swsb_pkg::out_item_t        out_item_o
);
  import swsb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_MOD,
    S_RD_DATA,
    S_WR_MOD,
    S_ADV_MOD,
    S_ADV_CLR,
    S_BASE_MOD,
    S_DONE
  } state_e;

  state_e            state_q;
  in_item_t          item_q;
  out_item_t         res_q;
  out_item_t         out_q;
  logic              out_valid_q;
  logic [SizeW-1:0]  window_size_q;
  logic [SlotAw-1:0] base_q;
  logic [SlotAw-1:0] ptr_q;
  logic [SizeW-1:0]  cnt_q;
  logic              err_q;
  logic [SizeW-1:0]  size_clamped;
  logic              in_accept;
  logic              mod_start;
  logic [SumW-1:0]   mod_dividend;
  logic              mod_done;
  logic [SlotAw-1:0] mod_rem;
  store_cmd_t        store_cmd;
  logic              rd_present;
  logic [ValueW-1:0] rd_value;
  logic [SizeW-1:0]  ptr_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ptr_inc    = {1'b0, ptr_q} + 1'b1;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      size_clamped = SizeW'(1);
    end else if (cfg_wdata_i > SizeW'(MaxSlots)) begin
      size_clamped = SizeW'(MaxSlots);
    end else begin
      size_clamped = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= SizeW'(MaxSlots);
    end else if (cfg_we_i) begin
      window_size_q <= size_clamped;
    end
  end

  // remainder unit requests
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = SumW'(item_q.offset) + SumW'(base_q);
    unique case (state_q)
      S_IDLE: begin
        mod_dividend = SumW'(in_item_i.offset) + SumW'(base_q);
        if (in_accept) begin
          unique case (req_e'(in_item_i.req_type))
            REQ_READ:    mod_start = 1'b1;
            REQ_WRITE:   mod_start = (in_item_i.offset < OffW'(window_size_q));
            REQ_ADVANCE: begin
              mod_start    = 1'b1;
              mod_dividend = SumW'(base_q);
            end
            REQ_NOP:     mod_start = 1'b0;
          endcase
        end
      end
      S_ADV_CLR: mod_start = (cnt_q == '0) && !err_q;
      default:   mod_start = 1'b0;
    endcase
  end

  // slot store requests
  always_comb begin
    store_cmd = '0;
    unique case (state_q)
      S_RD_MOD: begin
        store_cmd.rd_en = mod_done;
        store_cmd.addr  = mod_rem;
      end
      S_WR_MOD: begin
        store_cmd.wr_en      = mod_done;
        store_cmd.wr_present = item_q.write_present;
        store_cmd.addr       = mod_rem;
      end
      S_ADV_CLR: begin
        store_cmd.wr_en = (cnt_q != '0);
        store_cmd.addr  = ptr_q;
      end
      default: store_cmd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            item_q <= in_item_i;
            unique case (req_e'(in_item_i.req_type))
              REQ_READ: begin
                res_q   <= '0;
                state_q <= S_RD_MOD;
              end
              REQ_WRITE: begin
                if (in_item_i.offset < OffW'(window_size_q)) begin
                  res_q   <= '0;
                  state_q <= S_WR_MOD;
                end else begin
                  res_q   <= '{1'b0, ValueW'(0), 1'b1};
                  state_q <= S_DONE;
                end
              end
              REQ_ADVANCE: begin
                res_q <= '0;
                if (in_item_i.offset > OffW'(window_size_q)) begin
                  cnt_q <= window_size_q;
                  err_q <= 1'b1;
                end else begin
                  cnt_q <= in_item_i.offset[SizeW-1:0];
                  err_q <= 1'b0;
                end
                state_q <= S_ADV_MOD;
              end
              REQ_NOP: begin
                res_q   <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_RD_MOD: begin
          if (mod_done) begin
            state_q <= S_RD_DATA;
          end
        end
        S_RD_DATA: begin
          res_q.read_present <= rd_present;
          res_q.read_value   <= rd_value;
          state_q            <= S_DONE;
        end
        S_WR_MOD: begin
          if (mod_done) begin
            state_q <= S_DONE;
          end
        end
        S_ADV_MOD: begin
          if (mod_done) begin
            ptr_q   <= mod_rem;
            state_q <= S_ADV_CLR;
          end
        end
        S_ADV_CLR: begin
          if (cnt_q == '0) begin
            if (err_q) begin
              res_q.status <= 1'b1;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_BASE_MOD;
            end
          end else begin
            cnt_q <= cnt_q - 1'b1;
            if (ptr_inc == window_size_q) begin
              ptr_q <= '0;
            end else begin
              ptr_q <= ptr_inc[SlotAw-1:0];
            end
          end
        end
        S_BASE_MOD: begin
          if (mod_done) begin
            base_q  <= mod_rem;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  swsb_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (window_size_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  swsb_slot_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (store_cmd),
    .wdata_i      (item_q.write_value),
    .rd_present_o (rd_present),
    .rd_value_o   (rd_value)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[test/sliding_window_slot_buffer_unit_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_slot_buffer_unit_test
// self-checking bench for the sliding window slot buffer: a directed table,
// then random traffic over several window sizes, scored item by item against
// a local predictor of the slot store and base index, with random gaps on
// both the request and the result channel
// ----------------------------------------------------------------------------
module sliding_window_slot_buffer_unit_test;

  import swsb_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 320;
  localparam int unsigned DirCount   = 25;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 72;

  typedef struct packed {
    req_e              req;
    logic [OffW-1:0]   offset;
    logic              wpres;
    logic [ValueW-1:0] wval;
    logic              fixed;
    out_item_t         want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SizeW-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  out_item_t         out_item_o;

  // predicted slot store
  bit [ValueW-1:0]   slot_value  [MaxSlots];
  bit                slot_full   [MaxSlots];
  bit                slot_loaded [MaxSlots];
  int unsigned       base_slot  = 0;
  int unsigned       window_len = MaxSlots;

  out_item_t         expected_results [$];
  dir_row_t          dir_rows [DirCount];
  int unsigned       mismatches = 0;
  int unsigned       cycles     = 0;
  bit                calm       = 1'b0;

  sliding_window_slot_buffer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic out_item_t window_predict(in_item_t it);
    out_item_t   r;
    int unsigned idx;
    int unsigned n;
    r = '0;
    case (req_e'(it.req_type))
      REQ_READ: begin
        idx = (base_slot + it.offset) % window_len;
        if (slot_full[idx]) begin
          r.read_present = 1'b1;
          r.read_value   = slot_value[idx];
        end
      end
      REQ_WRITE: begin
        if (it.offset >= window_len) begin
          r.status = 1'b1;
        end else begin
          idx = (base_slot + it.offset) % window_len;
          slot_full[idx]  = it.write_present;
          slot_value[idx] = it.write_present ? it.write_value : '0;
          if (it.write_present) slot_loaded[idx] = 1'b1;
        end
      end
      REQ_ADVANCE: begin
        if (it.offset > window_len) begin
          for (n = 0; n < window_len; n++) begin
            slot_full[(base_slot + n) % window_len]  = 1'b0;
            slot_value[(base_slot + n) % window_len] = '0;
          end
          r.status = 1'b1;
        end else begin
          for (n = 0; n < it.offset; n++) begin
            slot_full[(base_slot + n) % window_len]  = 1'b0;
            slot_value[(base_slot + n) % window_len] = '0;
          end
          base_slot = (base_slot + it.offset) % window_len;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // reads only target slots that have held a value
  function automatic in_item_t gen_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned idx;
    int unsigned off0;
    int unsigned kmax;
    int unsigned tries;
    int unsigned r;
    bit          found;
    it.req_type      = REQ_NOP;
    it.offset        = OffW'($urandom);
    it.write_present = 1'($urandom);
    it.write_value   = $urandom;
    found = 1'b0;
    idx   = 0;
    pick  = $urandom_range(0, 99);
    if (pick < 38) begin
      for (tries = 0; tries < 8 && !found; tries++) begin
        idx   = $urandom_range(0, window_len - 1);
        found = slot_loaded[idx];
      end
      if (found) begin
        off0 = (idx + window_len - (base_slot % window_len)) % window_len;
        kmax = (65535 - off0) / window_len;
        it.req_type = REQ_READ;
        it.offset   = OffW'(off0 + window_len *
                      (($urandom_range(0, 2) == 0) ? $urandom_range(0, kmax) : 0));
      end else begin
        pick = 40;
      end
    end
    if (!found) begin
      if (pick < 75) begin
        it.req_type      = REQ_WRITE;
        it.write_present = ($urandom_range(0, 6) != 0);
        if ($urandom_range(0, 4) == 0) it.offset = OffW'($urandom_range(window_len, 65535));
        else it.offset = OffW'($urandom_range(0, window_len - 1));
      end else if (pick < 94) begin
        it.req_type = REQ_ADVANCE;
        r = $urandom_range(0, 19);
        if (r < 14) it.offset = OffW'($urandom_range(0, (window_len < 8) ? window_len : 8));
        else if (r < 16) it.offset = OffW'($urandom_range(0, window_len));
        else if (r < 18) it.offset = OffW'(window_len);
        else it.offset = OffW'($urandom_range(window_len + 1, 65535));
      end
    end
    return it;
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected item, expected none, got %h", $time, got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.read_present !== want.read_present) begin
        $display("%0t: read_present expected %b got %b", $time,
                 want.read_present, got.read_present);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h got %h", $time,
                 want.read_value, got.read_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %b got %b", $time, want.status, got.status);
        mismatches++;
      end
    end
  endtask

  task automatic send_item(in_item_t it, logic fixed, out_item_t fixed_want);
    out_item_t   want;
    int unsigned gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    want = window_predict(it);
    expected_results.push_back(fixed ? fixed_want : want);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_window(logic [SizeW-1:0] v);
    settle();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_len = (v == 0) ? 1 : ((v > MaxSlots) ? MaxSlots : v);
  endtask

  initial begin : result_side
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = idle_draw();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      check_result(out_item_o);
    end
  end

  initial begin : request_side
    int unsigned      ph;
    int unsigned      n;
    logic [SizeW-1:0] v;
    in_item_t         it;
    dir_row_t         row;

    dir_rows[0]  = '{REQ_WRITE,   16'd0,     1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[1]  = '{REQ_READ,    16'd0,     1'b0, 32'h0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}};
    dir_rows[2]  = '{REQ_WRITE,   16'd255,   1'b1, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[3]  = '{REQ_READ,    16'd255,   1'b0, 32'h0, 1'b1, '{1'b1, 32'h0, 1'b0}};
    dir_rows[4]  = '{REQ_READ,    16'd65535, 1'b0, 32'h0, 1'b1, '{1'b1, 32'h0, 1'b0}};
    dir_rows[5]  = '{REQ_WRITE,   16'd256,   1'b1, 32'hA5A5_A5A5, 1'b1, '{1'b0, 32'h0, 1'b1}};
    dir_rows[6]  = '{REQ_WRITE,   16'd65535, 1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b1}};
    dir_rows[7]  = '{REQ_WRITE,   16'd1,     1'b1, 32'h1234_5678, 1'b0, '0};
    dir_rows[8]  = '{REQ_WRITE,   16'd1,     1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[9]  = '{REQ_READ,    16'd1,     1'b0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[10] = '{REQ_READ,    16'd257,   1'b0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[11] = '{REQ_NOP,     16'd65535, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[12] = '{REQ_WRITE,   16'd2,     1'b1, 32'hDEAD_BEEF, 1'b0, '0};
    dir_rows[13] = '{REQ_ADVANCE, 16'd2,     1'b0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[14] = '{REQ_READ,    16'd0,     1'b0, 32'h0, 1'b0, '0};
    dir_rows[15] = '{REQ_READ,    16'd254,   1'b0, 32'h0, 1'b0, '0};
    dir_rows[16] = '{REQ_ADVANCE, 16'd0,     1'b0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0}};
    dir_rows[17] = '{REQ_ADVANCE, 16'd256,   1'b0, 32'h0, 1'b0, '0};
    dir_rows[18] = '{REQ_READ,    16'd0,     1'b0, 32'h0, 1'b0, '0};
    dir_rows[19] = '{REQ_WRITE,   16'd0,     1'b1, 32'h0000_0001, 1'b0, '0};
    dir_rows[20] = '{REQ_ADVANCE, 16'd257,   1'b0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b1}};
    dir_rows[21] = '{REQ_READ,    16'd0,     1'b0, 32'h0, 1'b0, '0};
    dir_rows[22] = '{REQ_ADVANCE, 16'd65535, 1'b0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b1}};
    dir_rows[23] = '{REQ_WRITE,   16'd253,   1'b1, 32'h8000_0000, 1'b0, '0};
    dir_rows[24] = '{REQ_READ,    16'd65533, 1'b0, 32'h0, 1'b0, '0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DirCount; n++) begin
      row = dir_rows[n];
      it.req_type      = row.req;
      it.offset        = row.offset;
      it.write_present = row.wpres;
      it.write_value   = row.wval;
      send_item(it, row.fixed, row.want);
    end

    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       v = 9'd1;
        1:       v = 9'd0;
        2:       v = 9'd2;
        3:       v = 9'd511;
        4:       v = 9'd255;
        5:       v = SizeW'($urandom_range(3, 254));
        6:       v = SizeW'($urandom_range(0, 511));
        default: v = 9'd256;
      endcase
      set_window(v);
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 36 == 0) calm = ($urandom_range(0, 3) == 0);
        // hold off until the pipeline is empty
        if (ph == 3 && n == PhaseItems / 2) settle();
        send_item(gen_item(), 1'b0, '0);
      end
    end

    settle();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
